### rtl/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// shared types and constants for the text console cursor and scroll core
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;
    localparam int KIND_W  = 2;
    localparam int RROW_W  = 5;
    localparam int RCOL_W  = 7;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

    localparam logic [3:0]        COLOR_BLACK      = 4'd0;
    localparam logic [3:0]        COLOR_LIGHT_GREY = 4'd7;
    localparam logic [ATTR_W-1:0] ATTR_RESET       = {COLOR_BLACK, COLOR_LIGHT_GREY};

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_imm;
        logic load_read;
        logic load_sweep;
        logic sweep_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_sweep;
        logic sweep_last;
    } status_t;

endpackage

### rtl/text_console_cursor_scroll_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// character-cell console: put, read and clear requests on a cursor-driven screen
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  in        in_valid, in_stall, kind, char_code,
//            read_row, read_col                              request in
//  out       out_valid, out_stall, cell_entry, cursor_row,
//            cursor_col, scrolled                            result out
//  cfg       cfg_valid, cfg_ready, cfg_data                  attribute write
//
//  a put without scroll and an unused kind load the result register on
//  acceptance; a cell read passes through the registered ram read first.
//  clear and a put that scrolls walk over the screen ram, one cell per cycle.
//  the result register is separate from the input side; a new request is
//  taken while the previous result leaves. reset clears the cursor and sets
//  the default attribute but not the screen ram, which holds garbage until the first clear.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tccs_pkg::KIND_W-1:0]   kind,
    input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccs_pkg::RROW_W-1:0]   read_row,
    input  logic [tccs_pkg::RCOL_W-1:0]   read_col,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tccs_pkg::CELL_W-1:0]   cell_entry,
    output logic [tccs_pkg::RROW_W-1:0]   cursor_row,
    output logic [tccs_pkg::RCOL_W-1:0]   cursor_col,
    output logic                          scrolled,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tccs_pkg::ATTR_W-1:0]   cfg_data
);

    tccs_pkg::cmd_t    cmd;
    tccs_pkg::status_t st;

    assign cfg_ready = 1'b1;

    tccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .cell_entry (cell_entry),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

endmodule

### rtl/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tccs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ctrl
// sequencer for request acceptance, cell reads and screen sweeps
// ----------------------------------------------------------------------------
module tccs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tccs_pkg::status_t st,
    output tccs_pkg::cmd_t    cmd
);

    tccs_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    // a request is taken only in idle and when the result register is free or draining
    assign in_stall = !((state_reg == tccs_pkg::ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (st.is_read)
                    begin
                        state_next = tccs_pkg::ST_READ_WAIT;
                    end
                    else if (st.is_sweep)
                    begin
                        state_next = tccs_pkg::ST_SWEEP;
                    end
                end
            end
            tccs_pkg::ST_READ_WAIT:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
            tccs_pkg::ST_SWEEP:
            begin
                if (st.sweep_last)
                begin
                    state_next = tccs_pkg::ST_DRAIN;
                end
            end
            tccs_pkg::ST_DRAIN:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        unique case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                cmd.load_imm = accept && !st.is_read && !st.is_sweep;
            end
            tccs_pkg::ST_READ_WAIT:
            begin
                cmd.load_read = 1'b1;
            end
            tccs_pkg::ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            tccs_pkg::ST_DRAIN:
            begin
                cmd.load_sweep = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall)
                          || cmd.load_imm || cmd.load_read || cmd.load_sweep;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/tccs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_datapath
// cursor, attribute, screen store, sweep pipeline and result register
// ----------------------------------------------------------------------------
module tccs_datapath #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tccs_pkg::cmd_t                cmd,
    output tccs_pkg::status_t             st,
    input  logic                          cfg_write,
    input  logic [tccs_pkg::ATTR_W-1:0]   cfg_data,
    input  logic [tccs_pkg::KIND_W-1:0]   kind,
    input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccs_pkg::RROW_W-1:0]   read_row,
    input  logic [tccs_pkg::RCOL_W-1:0]   read_col,
    output logic [tccs_pkg::CELL_W-1:0]   cell_entry,
    output logic [tccs_pkg::RROW_W-1:0]   cursor_row,
    output logic [tccs_pkg::RCOL_W-1:0]   cursor_col,
    output logic                          scrolled
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW     = $clog2(TOTAL);
    localparam int CELL_W = tccs_pkg::CELL_W;

    logic [RW-1:0]                  row_reg, row_next;
    logic [CW-1:0]                  col_reg, col_next;
    logic [tccs_pkg::ATTR_W-1:0]    attr_reg;
    logic [AW-1:0]                  idx_reg;
    logic                           stage_valid_reg;
    logic [AW-1:0]                  stage_addr_reg;
    logic                           stage_use_read_reg;
    logic [CELL_W-1:0]              fill_reg;
    logic                           copy_reg;
    logic                           scroll_flag_reg;
    logic                           read_ok_reg;
    logic [CELL_W-1:0]              entry_reg;
    logic [RW-1:0]                  out_row_reg;
    logic [CW-1:0]                  out_col_reg;
    logic                           scrolled_reg;

    logic                           is_put;
    logic                           is_read;
    logic                           is_clear;
    logic                           newline;
    logic [CW:0]                    col_inc;
    logic [RW:0]                    row_inc;
    logic                           row_up;
    logic                           put_scroll;
    logic                           read_ok;
    logic [AW-1:0]                  put_addr;
    logic [AW-1:0]                  rd_item_addr;
    logic [AW-1:0]                  copy_src;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [CELL_W-1:0]              ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [CELL_W-1:0]              ram_rdata;

    assign is_put   = (tccs_pkg::kind_t'(kind) == tccs_pkg::KIND_PUT);
    assign is_read  = (tccs_pkg::kind_t'(kind) == tccs_pkg::KIND_READ);
    assign is_clear = (tccs_pkg::kind_t'(kind) == tccs_pkg::KIND_CLEAR);
    assign newline  = (char_code == tccs_pkg::CODE_NEWLINE);

    // cursor advance with column wrap and bottom-row clamp
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + (CW+1)'(1);
        row_inc    = {1'b0, row_reg} + (RW+1)'(1);
        row_up     = 1'b0;
        put_scroll = 1'b0;
        col_next   = col_reg;
        row_next   = row_reg;
        if (newline || (32'(col_inc) >= COLUMNS))
        begin
            col_next = '0;
            row_up   = 1'b1;
        end
        else
        begin
            col_next = col_inc[CW-1:0];
        end
        if (row_up)
        begin
            if (32'(row_inc) >= ROWS)
            begin
                row_next   = RW'(ROWS - 1);
                put_scroll = 1'b1;
            end
            else
            begin
                row_next = row_inc[RW-1:0];
            end
        end
    end

    assign read_ok      = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    assign put_addr     = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign rd_item_addr = AW'(32'(read_row) * COLUMNS + 32'(read_col));
    assign copy_src     = AW'(32'(idx_reg) + COLUMNS);

    assign st.is_read    = is_read;
    assign st.is_sweep   = is_clear || (is_put && put_scroll);
    assign st.sweep_last = (idx_reg == AW'(TOTAL - 1));

    // sweep writes come in the cycle after their reads; no put can overlap a sweep
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = put_addr;
        ram_wdata = {attr_reg, char_code};
        if (stage_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = stage_addr_reg;
            ram_wdata = stage_use_read_reg ? ram_rdata : fill_reg;
        end
        else if (cmd.accept && is_put && !newline)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = cmd.sweep_step ? copy_src : rd_item_addr;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= '0;
            col_reg         <= '0;
            attr_reg        <= tccs_pkg::ATTR_RESET;
            idx_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
            if (cmd.accept && is_put)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            stage_valid_reg <= cmd.sweep_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            copy_reg        <= is_put;
            scroll_flag_reg <= is_put && put_scroll;
            fill_reg        <= is_clear ? {attr_reg, tccs_pkg::CODE_SPACE} : '0;
            read_ok_reg     <= read_ok;
        end
        if (cmd.sweep_step)
        begin
            stage_addr_reg     <= idx_reg;
            stage_use_read_reg <= copy_reg && (32'(idx_reg) < COPY_N);
        end
        if (cmd.load_imm)
        begin
            entry_reg    <= '0;
            out_row_reg  <= is_put ? row_next : row_reg;
            out_col_reg  <= is_put ? col_next : col_reg;
            scrolled_reg <= 1'b0;
        end
        else if (cmd.load_read)
        begin
            entry_reg    <= read_ok_reg ? ram_rdata : '0;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            scrolled_reg <= 1'b0;
        end
        else if (cmd.load_sweep)
        begin
            entry_reg    <= '0;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            scrolled_reg <= scroll_flag_reg;
        end
    end

    assign cell_entry = entry_reg;
    assign cursor_row = tccs_pkg::RROW_W'(out_row_reg);
    assign cursor_col = tccs_pkg::RCOL_W'(out_col_reg);
    assign scrolled   = scrolled_reg;

endmodule
